// ----- hw/rtl/rsttrk_pkg.sv -----
// shared types and constants of the row staleness tracker
package rsttrk_pkg;

	localparam int ROW_W   = 20;
	localparam int RROWS_W = 7;
	localparam int RWRK_W  = 5;
	localparam int FUNC_W  = 3;
	localparam int WID_W   = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [FUNC_W-1:0] FUNC_ADD_ROW   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD_ALL   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_GET_ROW   = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_GET_ALL   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_GET_UNTRK = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WORKERS_IN_USE = 2'd2;

	localparam logic [ROW_W-1:0]   RST_ROW_OFFSET     = 20'd0;
	localparam logic [RROWS_W-1:0] RST_ROWS_IN_USE    = 7'd64;
	localparam logic [RWRK_W-1:0]  RST_WORKERS_IN_USE = 5'd16;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [WID_W-1:0]  wkr;
		logic [ROW_W-1:0]  row_id;
		logic              last_key;
	} req_t;

	typedef struct packed {
		logic [ROW_W-1:0] row_out;
		logic             last_of_run;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_READ,
		ST_CHECK,
		ST_LAST
	} state_t;

	typedef struct packed {
		logic load_req;
		logic clr_pend;
		logic cnt_load;
		logic cnt_sel_all;
		logic rd_en;
		logic visit;
		logic cnt_inc;
		logic emit_last;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              last_key;
		logic              held;
		logic              rlim_zero;
		logic              cnt_last;
		logic              need_emit;
		logic              slot_free;
		logic              pend_vld;
	} sts_t;

endpackage

// ----- hw/rtl/rsttrk_ram.sv -----
// generic single write port ram with registered read
module rsttrk_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

// ----- hw/rtl/rsttrk_ctrl.sv -----
// sequencing state machine of the row staleness tracker
module rsttrk_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rsttrk_pkg::sts_t sts,
	output rsttrk_pkg::cmd_t cmd
);

	import rsttrk_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   blocked;

	// a pending row must leave before a new one takes its place
	assign blocked = sts.need_emit && !sts.slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				unique case (sts.func) inside
					FUNC_ADD_ROW, FUNC_GET_ROW: begin
						if (sts.held) begin
							state_d = ST_READ;
						end else if (sts.func == FUNC_GET_ROW && sts.last_key) begin
							state_d = ST_LAST;
						end else begin
							state_d = ST_IDLE;
						end
					end
					FUNC_ADD_ALL: begin
						state_d = sts.rlim_zero ? ST_IDLE : ST_READ;
					end
					FUNC_GET_ALL, FUNC_GET_UNTRK: begin
						state_d = sts.rlim_zero ? ST_LAST : ST_READ;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!blocked) begin
					unique case (sts.func) inside
						FUNC_GET_ROW: begin
							state_d = sts.last_key ? ST_LAST : ST_IDLE;
						end
						FUNC_ADD_ALL: begin
							state_d = sts.cnt_last ? ST_IDLE : ST_READ;
						end
						FUNC_GET_ALL, FUNC_GET_UNTRK: begin
							state_d = sts.cnt_last ? ST_LAST : ST_READ;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_LAST: begin
				if (sts.slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall    = 1'b0;
				cmd.load_req = req_valid;
			end
			ST_START: begin
				cmd.cnt_load = 1'b1;
				unique case (sts.func) inside
					FUNC_ADD_ALL: begin
						cmd.cnt_sel_all = 1'b1;
					end
					FUNC_GET_ALL, FUNC_GET_UNTRK: begin
						cmd.cnt_sel_all = 1'b1;
						cmd.clr_pend    = 1'b1;
					end
					default: begin
						cmd.cnt_sel_all = 1'b0;
					end
				endcase
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
			end
			ST_CHECK: begin
				cmd.visit   = !blocked;
				cmd.cnt_inc = !blocked && !sts.cnt_last;
			end
			ST_LAST: begin
				cmd.emit_last = sts.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- hw/rtl/rsttrk_dpath.sv -----
// datapath: config registers, freshness store, pending row and output register
module rsttrk_dpath #(
	parameter int ROWS    = 64,
	parameter int WORKERS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rsttrk_pkg::req_t                    req_data,
	output rsttrk_pkg::rsp_t                    rsp_data,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	input  logic                                cfg_we,
	input  logic [rsttrk_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rsttrk_pkg::ROW_W-1:0]        cfg_data,
	input  rsttrk_pkg::cmd_t                    cmd,
	output rsttrk_pkg::sts_t                    sts
);

	import rsttrk_pkg::*;

	localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;

	req_t               req_q;
	logic [ROW_W-1:0]   off_q;
	logic [RROWS_W-1:0] rows_q;
	logic [RWRK_W-1:0]  wrk_q;
	logic [RAW-1:0]     cnt_q;
	logic [ROW_W-1:0]   pend_q;
	logic               pend_vld_q;
	logic               out_vld_q;
	rsp_t               out_q;
	logic [ROWS-1:0]    vld_q;
	logic               vld_rd_q;

	logic [RROWS_W-1:0] rlim;
	logic [ROW_W-1:0]   diff;
	logic               held;
	logic               tracked;
	logic [WORKERS-1:0] own;
	logic [WORKERS-1:0] slot_mask;
	logic [WORKERS-1:0] clear;
	logic [WORKERS-1:0] rdata;
	logic [WORKERS-1:0] word;
	logic [WORKERS-1:0] wdata;
	logic               is_add;
	logic               is_get;
	logic               is_untrk;
	logic               stale;
	logic               wr;
	logic               need_emit;
	logic               emit_pend;
	logic               slot_free;

	assign rlim = (rows_q > RROWS_W'(ROWS)) ? RROWS_W'(ROWS) : rows_q;
	assign diff = req_q.row_id - off_q;
	assign held = (req_q.row_id >= off_q) && (diff < ROW_W'(rlim));

	assign tracked = ({1'b0, req_q.wkr} < wrk_q) && (int'(req_q.wkr) < WORKERS);
	assign own     = tracked ? (WORKERS'(1) << req_q.wkr) : '0;

	always_comb begin
		for (int i = 0; i < WORKERS; i++) begin
			slot_mask[i] = i < int'(wrk_q);
		end
	end

	assign clear = slot_mask & ~own;

	assign is_add   = (req_q.func == FUNC_ADD_ROW) || (req_q.func == FUNC_ADD_ALL);
	assign is_untrk = req_q.func == FUNC_GET_UNTRK;
	assign is_get   = (req_q.func == FUNC_GET_ROW) || (req_q.func == FUNC_GET_ALL) || is_untrk;

	// never-written rows read as all stale
	assign word  = vld_rd_q ? rdata : '0;
	assign stale = is_untrk || !tracked || ((word & own) == '0);
	assign wdata = is_add ? (word & ~clear) : (word | own);
	assign wr    = cmd.visit && (is_add || (is_get && !is_untrk && stale));

	assign need_emit = is_get && stale && pend_vld_q;
	assign emit_pend = cmd.visit && need_emit;
	assign slot_free = !out_vld_q || !rsp_stall;

	rsttrk_ram #(
		.WIDTH (WORKERS),
		.DEPTH (ROWS),
		.AW    (RAW)
	) u_fresh_ram (
		.clk   (clk),
		.we    (wr),
		.waddr (cnt_q),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (cnt_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req_data;
		end
		if (cmd.cnt_load) begin
			cnt_q <= cmd.cnt_sel_all ? '0 : diff[RAW-1:0];
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + RAW'(1);
		end
		if (cmd.visit && is_get && stale) begin
			pend_q <= off_q + ROW_W'(cnt_q);
		end
		if (cmd.rd_en) begin
			vld_rd_q <= vld_q[cnt_q];
		end
		if (emit_pend) begin
			out_q.row_out     <= pend_q;
			out_q.last_of_run <= 1'b0;
		end else if (cmd.emit_last) begin
			out_q.row_out     <= pend_vld_q ? pend_q : off_q;
			out_q.last_of_run <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q      <= RST_ROW_OFFSET;
			rows_q     <= RST_ROWS_IN_USE;
			wrk_q      <= RST_WORKERS_IN_USE;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
			vld_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROW_OFFSET:     off_q  <= cfg_data;
					CFG_ROWS_IN_USE:    rows_q <= cfg_data[RROWS_W-1:0];
					CFG_WORKERS_IN_USE: wrk_q  <= cfg_data[RWRK_W-1:0];
					default:            off_q  <= off_q;
				endcase
			end
			if (cmd.clr_pend || cmd.emit_last) begin
				pend_vld_q <= 1'b0;
			end else if (cmd.visit && is_get && stale) begin
				pend_vld_q <= 1'b1;
			end
			if (emit_pend || cmd.emit_last) begin
				out_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_vld_q <= 1'b0;
			end
			if (wr) begin
				vld_q[cnt_q] <= 1'b1;
			end
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp_data  = out_q;

	assign sts.func      = req_q.func;
	assign sts.last_key  = req_q.last_key;
	assign sts.held      = held;
	assign sts.rlim_zero = rlim == '0;
	assign sts.cnt_last  = (RROWS_W'(cnt_q) + RROWS_W'(1)) == rlim;
	assign sts.need_emit = need_emit;
	assign sts.slot_free = slot_free;
	assign sts.pend_vld  = pend_vld_q;

endmodule

// ----- hw/rtl/row_staleness_tracker_top.sv -----
// top level of the row staleness tracker
// held-key add or get: start, read, check states; a key outside the held range: start only
// add-all and whole-table gets: start, then a ram read and a check per held row
// a get closing a run emits its closing row in a last state; results leave via one register
// a result waiting on a stalled output register holds the sequence until the register frees
// reset clears control state and marks every row stale at once through per-row valid bits
module row_staleness_tracker_top #(
	parameter int ROWS    = 64,
	parameter int WORKERS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  rsttrk_pkg::req_t                 req_data,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output rsttrk_pkg::rsp_t                 rsp_data,
	input  logic                             cfg_we,
	input  logic [rsttrk_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsttrk_pkg::ROW_W-1:0]     cfg_data
);

	import rsttrk_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rsttrk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rsttrk_dpath #(
		.ROWS    (ROWS),
		.WORKERS (WORKERS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.rsp_data  (rsp_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("controller did not leave idle after a request");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.visit && sts.need_emit) || cmd.emit_last) |-> sts.slot_free)
		else $error("result written while output register busy");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_last |=> (!sts.pend_vld && rsp_valid && rsp_data.last_of_run))
		else $error("closing row did not clear pending state");
`endif

endmodule
